// ===== rtl/lfu_pkg.sv =====
// shared constants, request/result types, controller states and control structs
package lfu_pkg;

    localparam int MAX_FRAMES = 8;
    localparam int PAGE_BITS  = 8;
    localparam int PAGE_COUNT = 1 << PAGE_BITS;
    localparam int CNT_W      = 16;
    localparam int CFG_W      = 4;
    localparam int OCC_W      = $clog2(MAX_FRAMES + 1);
    localparam int IDX_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

    localparam logic [CFG_W-1:0] CAP_RESET = 4'd8;

    typedef struct packed {
        logic [7:0] page_number;
        logic       last_ref;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic [15:0] fault_total;
        logic        final_res;
    } t_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_WRITE,
        S_BUBBLE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic update;
        logic wr_page;
        logic bub_step;
        logic done;
    } t_cmd;

    typedef struct packed {
        logic bub_stop;
    } t_sts;

endpackage

// ===== rtl/lfu_ctrl.sv =====
// sequencing state machine for one page request
module lfu_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  lfu_pkg::t_sts i_sts,
    output lfu_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    import lfu_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_WRITE;
            end
            S_WRITE: begin
                o_cmd.wr_page = 1'b1;
                n_state       = S_BUBBLE;
            end
            S_BUBBLE: begin
                if (i_sts.bub_stop) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.bub_step = 1'b1;
                end
            end
            S_DONE: begin
                o_cmd.done = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== rtl/lfu_dp.sv =====
// frame list, use count memory, fault counter and capacity register
module lfu_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  lfu_pkg::t_cmd             i_cmd,
    input  lfu_pkg::t_req             i_req,
    input  logic                      i_cfg_we,
    input  logic [lfu_pkg::CFG_W-1:0] i_cfg_wdata,
    output lfu_pkg::t_sts             o_sts,
    output lfu_pkg::t_res             o_res
);
    import lfu_pkg::*;

    logic [CFG_W-1:0]     r_cap_cfg;
    logic [PAGE_BITS-1:0] r_page;
    logic                 r_last;
    logic [PAGE_BITS-1:0] r_slot_page [MAX_FRAMES];
    logic [CNT_W-1:0]     r_slot_cnt  [MAX_FRAMES];
    logic [OCC_W-1:0]     r_occ;
    logic [CNT_W-1:0]     r_fault;
    logic                 r_found;
    logic [IDX_W-1:0]     r_k;
    logic [CNT_W-1:0]     r_new_cnt;

    logic [CNT_W-1:0]     r_mem [PAGE_COUNT];
    logic [PAGE_COUNT-1:0] r_vld;
    logic [CNT_W-1:0]     r_rd_data;
    logic                 r_rd_vld;

    logic [OCC_W-1:0]     cap;
    logic                 found;
    logic [IDX_W-1:0]     pos;
    logic                 evict;
    logic                 do_rm;
    logic [IDX_W-1:0]     rm_pos;
    logic [OCC_W-1:0]     occ_rm;
    logic [CNT_W-1:0]     old_cnt;
    logic [CNT_W-1:0]     new_cnt;
    logic [CNT_W-1:0]     vict_dec;
    logic [PAGE_BITS-1:0] sh_page [MAX_FRAMES];
    logic [CNT_W-1:0]     sh_cnt  [MAX_FRAMES];
    logic [IDX_W-1:0]     km1;
    logic                 mem_we;
    logic [PAGE_BITS-1:0] mem_waddr;
    logic [CNT_W-1:0]     mem_wdata;
    logic                 seq_clear;

    // effective capacity: zero acts as one, clamp at frame count
    always_comb begin
        if (r_cap_cfg == '0) begin
            cap = OCC_W'(1);
        end else if (int'(r_cap_cfg) > MAX_FRAMES) begin
            cap = OCC_W'(MAX_FRAMES);
        end else begin
            cap = OCC_W'(r_cap_cfg);
        end
    end

    // parallel tag compare, lowest slot wins
    always_comb begin
        found = 1'b0;
        pos   = '0;
        for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
            if ((OCC_W'(i) < r_occ) && (r_slot_page[i] == r_page)) begin
                found = 1'b1;
                pos   = IDX_W'(i);
            end
        end
    end

    assign evict    = !found && (r_occ >= cap);
    assign do_rm    = found || evict;
    assign rm_pos   = found ? pos : '0;
    assign occ_rm   = r_occ - OCC_W'(do_rm);
    assign old_cnt  = r_rd_vld ? r_rd_data : '0;
    assign new_cnt  = (old_cnt == '1) ? old_cnt : old_cnt + 1'b1;
    assign vict_dec = (r_slot_cnt[0] == '0) ? '0 : r_slot_cnt[0] - 1'b1;

    // list shifted down by one slot, used for removal
    always_comb begin
        for (int i = 0; i < MAX_FRAMES - 1; i++) begin
            sh_page[i] = r_slot_page[i+1];
            sh_cnt[i]  = r_slot_cnt[i+1];
        end
        sh_page[MAX_FRAMES-1] = r_slot_page[MAX_FRAMES-1];
        sh_cnt[MAX_FRAMES-1]  = r_slot_cnt[MAX_FRAMES-1];
    end

    // bubble compare, bound tested first
    assign km1            = r_k - 1'b1;
    assign o_sts.bub_stop = (r_k == '0) || !(r_slot_cnt[km1] > r_slot_cnt[r_k]);

    assign seq_clear = i_cmd.done && r_last;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_cfg <= CAP_RESET;
            r_occ     <= '0;
            r_fault   <= '0;
            r_vld     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cap_cfg <= i_cfg_wdata;
            end
            if (i_cmd.update) begin
                r_occ <= occ_rm + 1'b1;
                if (!found && (r_fault != '1)) begin
                    r_fault <= r_fault + 1'b1;
                end
            end
            if (mem_we) begin
                r_vld[mem_waddr] <= 1'b1;
            end
            if (seq_clear) begin
                r_occ   <= '0;
                r_fault <= '0;
                r_vld   <= '0;
            end
        end
    end

    // request payload and frame list
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_page <= i_req.page_number[PAGE_BITS-1:0];
            r_last <= i_req.last_ref;
        end
        if (i_cmd.update) begin
            r_found   <= found;
            r_k       <= IDX_W'(occ_rm);
            r_new_cnt <= new_cnt;
            for (int i = 0; i < MAX_FRAMES; i++) begin
                if (OCC_W'(i) == occ_rm) begin
                    r_slot_page[i] <= r_page;
                    r_slot_cnt[i]  <= new_cnt;
                end else if (do_rm && (IDX_W'(i) >= rm_pos)) begin
                    r_slot_page[i] <= sh_page[i];
                    r_slot_cnt[i]  <= sh_cnt[i];
                end
            end
        end
        if (i_cmd.bub_step) begin
            r_slot_page[km1] <= r_slot_page[r_k];
            r_slot_cnt[km1]  <= r_slot_cnt[r_k];
            r_slot_page[r_k] <= r_slot_page[km1];
            r_slot_cnt[r_k]  <= r_slot_cnt[km1];
            r_k              <= km1;
        end
    end

    // use count memory: victim write-back on update, new count on write
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_page;
        mem_wdata = r_new_cnt;
        if (i_cmd.update && evict) begin
            mem_we    = 1'b1;
            mem_waddr = r_slot_page[0];
            mem_wdata = vict_dec;
        end else if (i_cmd.wr_page) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.load) begin
            r_rd_data <= r_mem[i_req.page_number[PAGE_BITS-1:0]];
            r_rd_vld  <= r_vld[i_req.page_number[PAGE_BITS-1:0]];
        end
    end

    assign o_res.hit         = r_found;
    assign o_res.fault_total = r_fault;
    assign o_res.final_res   = r_last;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_occ) <= MAX_FRAMES)
        else $error("frame occupancy above frame count");

    a_bubble_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.bub_step |-> (r_k != '0))
        else $error("bubble step past list head");

    a_seq_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_clear |=> (r_occ == '0) && (r_fault == '0) && (r_vld == '0))
        else $error("state not cleared after final request");

    a_fault_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !seq_clear |=> (r_fault >= $past(r_fault)))
        else $error("fault total decreased without sequence end");

endmodule

// ===== rtl/lfu_page_replacement_top.sv =====
// top level of the lfu page replacement block
//
//  channel   ports                         direction  handshake
//  request   start, i_req                  in         taken when start && !busy
//  result    o_res_valid, o_res            out        one-cycle strobe, no backpressure
//  config    i_cfg_we, i_cfg_wdata         in         written on any edge with i_cfg_we
//
// - a request passes from acceptance to its result strobe through these steps:
//   accept, list update, count write, one bubble compare per position moved plus one
//   to stop, result
// - the bubble pass over the frame list varies in length; it walks one slot per cycle
// - busy falls in the cycle after the strobe, so the next request may follow at once
// - reset (synchronous, active low) empties the list, zeroes the fault total and marks
//   every use count invalid at once, so no clearing pass is needed
// - the result receiver cannot stall; the result fields are valid only with the strobe,
//   since a final request clears the fault total right after it
module lfu_page_replacement_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    input  lfu_pkg::t_req             i_req,
    output logic                      busy,
    input  logic                      i_cfg_we,
    input  logic [lfu_pkg::CFG_W-1:0] i_cfg_wdata,
    output logic                      o_res_valid,
    output lfu_pkg::t_res             o_res
);
    import lfu_pkg::*;

    // command and status between sequencer and datapath
    t_cmd cmd;
    t_sts sts;

    // sequencer: one request at a time, bubble loop waits on datapath status
    lfu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // datapath: frame list registers, count memory with valid bits, counters
    lfu_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_sts       (sts),
        .o_res       (o_res)
    );

    // result strobe comes from the final sequencer state
    assign o_res_valid = cmd.done;

endmodule

// ===== bench/testbench.sv =====
// self-checking bench for the lfu page replacement block with a built-in lfu predictor
module testbench;
    import lfu_pkg::*;

    // idle cycles with neither a request taken nor a result seen before giving up
    localparam int WATCHDOG = 1000;
    // settle time after the last result, well above the longest request latency
    localparam int TAIL_CYCLES = 16;

    // one page reference waiting to be driven, with its lead-in gap
    typedef struct {
        t_req        req;
        int unsigned gap;
    } t_pending_ref;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    t_req i_req = '0;
    logic busy;
    logic i_cfg_we = 1'b0;
    logic [CFG_W-1:0] i_cfg_wdata = '0;
    logic o_res_valid;
    t_res o_res;

    lfu_page_replacement_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_req       (i_req),
        .busy        (busy),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    always #6 i_clk = ~i_clk;

    // stimulus and expectations
    t_pending_ref ref_queue [$];
    t_res         outcome_q [$];
    int           cap_plan [$] = '{3, 1, 0, 15, 9, 2, 5, 8, 4, 7, 6, 12};

    // predictor state: resident list in lfu order, per-page use counts, fault total
    logic [7:0]       frames [MAX_FRAMES];
    int               resident;
    logic [CNT_W-1:0] use_count [PAGE_COUNT];
    logic [CNT_W-1:0] faults;
    logic [CFG_W-1:0] frame_limit;

    // bookkeeping
    logic took = 1'b0;
    int   gap_count = 0;
    int   idle_cycles = 0;
    int   n_requests = 0;
    int   n_hits = 0;
    int   n_ends = 0;
    int   n_settings = 0;
    int   n_bad = 0;
    t_res want;
    t_pending_ref nxt_ref;

    // back to the empty state; the frame limit survives a sequence end
    function automatic void clear_lfu_state();
        int p;
        for (p = 0; p < PAGE_COUNT; p++) use_count[p] = '0;
        for (p = 0; p < MAX_FRAMES; p++) frames[p] = '0;
        resident = 0;
        faults = '0;
    endfunction

    // one page reference through the lfu policy, returns the result it must produce
    function automatic t_res apply_reference(input t_req r);
        t_res       res;
        logic [7:0] pg;
        logic [7:0] tmp;
        int         cap;
        int         pos;
        int         i;
        int         k;
        bit         found;
        bit         drop;
        pg = r.page_number;
        // zero acts as one frame, anything past the array is clamped
        if (frame_limit == 0) cap = 1;
        else if (frame_limit > MAX_FRAMES) cap = MAX_FRAMES;
        else cap = frame_limit;
        found = 1'b0;
        pos = 0;
        for (i = 0; i < resident; i++) begin
            if (!found && frames[i] == pg) begin
                found = 1'b1;
                pos = i;
            end
        end
        drop = found;
        if (!found) begin
            // evict the least used head whenever the list is at or over the limit
            if (resident >= cap && resident > 0) begin
                if (use_count[frames[0]] != '0) use_count[frames[0]]--;
                pos = 0;
                drop = 1'b1;
            end
            if (faults != '1) faults++;
        end
        if (drop) begin
            for (i = pos; i + 1 < resident; i++) frames[i] = frames[i + 1];
            resident--;
        end
        frames[resident] = pg;
        resident++;
        if (use_count[pg] != '1) use_count[pg]++;
        // walk toward the head past strictly busier pages, never beyond slot zero
        k = resident - 1;
        while (k > 0 && use_count[frames[k - 1]] > use_count[frames[k]]) begin
            tmp = frames[k - 1];
            frames[k - 1] = frames[k];
            frames[k] = tmp;
            k--;
        end
        res.hit = found;
        res.fault_total = faults;
        res.final_res = r.last_ref;
        if (r.last_ref) clear_lfu_state();
        return res;
    endfunction

    // request driver: presents queued references at the falling edge, honoring gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_count <= 0;
        end else if (!start || took) begin
            if (ref_queue.size() != 0 && gap_count >= ref_queue[0].gap) begin
                nxt_ref = ref_queue.pop_front();
                i_req <= nxt_ref.req;
                start <= 1'b1;
                gap_count <= 0;
            end else begin
                start <= 1'b0;
                if (ref_queue.size() != 0) gap_count <= gap_count + 1;
            end
        end
    end

    // monitor: checks each result strobe, predicts each accepted request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            took <= 1'b0;
            frame_limit = CAP_RESET;
            clear_lfu_state();
        end else begin
            if (o_res_valid) begin
                if (outcome_q.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("result with nothing expected: hit %0b total %0d final %0b",
                                 o_res.hit, o_res.fault_total, o_res.final_res);
                end else begin
                    want = outcome_q.pop_front();
                    if (want.hit) n_hits++;
                    if (o_res.hit !== want.hit || o_res.fault_total !== want.fault_total ||
                        o_res.final_res !== want.final_res) begin
                        n_bad++;
                        if (n_bad <= 10)
                            $display("mismatch: hit %0b/%0b total %0d/%0d final %0b/%0b (exp/act)",
                                     want.hit, o_res.hit, want.fault_total, o_res.fault_total,
                                     want.final_res, o_res.final_res);
                    end
                end
            end
            if (start && !busy) begin
                outcome_q.insert(outcome_q.size(), apply_reference(i_req));
                n_requests++;
                if (i_req.last_ref) n_ends++;
            end
            took <= start && !busy;
            if (i_cfg_we) frame_limit = i_cfg_wdata;
        end
    end

    // watchdog on handshake activity
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_res_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG) begin
            $display("timeout: no request or result for %0d cycles", WATCHDOG);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic queue_ref(input logic [7:0] pg, input logic lst, input int unsigned gap);
        t_pending_ref e;
        e.req.page_number = pg;
        e.req.last_ref = lst;
        e.gap = gap;
        ref_queue.insert(ref_queue.size(), e);
    endtask

    // sender holds off until every request has come back, then lets busy settle
    task automatic wait_all_results();
        while (ref_queue.size() != 0 || start || outcome_q.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_frame_limit(input logic [CFG_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    // sequences over a small hot set so hits and evictions both show up,
    // with stray full-range pages and occasional early sequence ends as noise
    task automatic queue_random_refs(input int count, input bit burst);
        logic [7:0] hot [12];
        logic [7:0] pg;
        logic       lst;
        int         hot_n;
        int         seq_left;
        int         i;
        int         j;
        hot_n = 1;
        seq_left = 0;
        for (i = 0; i < count; i++) begin
            if (seq_left == 0) begin
                seq_left = $urandom_range(1, 40);
                hot_n = $urandom_range(1, 12);
                for (j = 0; j < hot_n; j++) hot[j] = 8'($urandom_range(0, 255));
            end
            if ($urandom_range(0, 9) < 7) pg = hot[$urandom_range(0, hot_n - 1)];
            else pg = 8'($urandom_range(0, 255));
            seq_left--;
            lst = (seq_left == 0) || ($urandom_range(0, 59) == 0);
            if (lst) seq_left = 0;
            queue_ref(pg, lst, burst ? 0 : $urandom_range(0, 8));
        end
    endtask

    initial begin
        int i;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset limit of eight frames, page extremes, hits that move
        // to the tail and bubble, evictions once full, sequence end clearing state
        queue_ref(8'd0, 1'b0, $urandom_range(0, 8));
        queue_ref(8'd255, 1'b0, $urandom_range(0, 8));
        queue_ref(8'd0, 1'b0, $urandom_range(0, 8));
        queue_ref(8'd255, 1'b0, $urandom_range(0, 8));
        queue_ref(8'd0, 1'b0, $urandom_range(0, 8));
        for (i = 0; i < 6; i++) queue_ref(8'd1 << i, 1'b0, $urandom_range(0, 8));
        queue_ref(8'd64, 1'b0, $urandom_range(0, 8));
        queue_ref(8'd128, 1'b0, $urandom_range(0, 8));
        queue_ref(8'd0, 1'b0, $urandom_range(0, 8));
        queue_ref(8'd170, 1'b1, $urandom_range(0, 8));
        queue_ref(8'd170, 1'b0, $urandom_range(0, 8));
        queue_ref(8'd170, 1'b0, $urandom_range(0, 8));
        queue_ref(8'd85, 1'b1, $urandom_range(0, 8));
        // refill all eight frames and leave the sequence open, so the first
        // limit write below shrinks capacity under a full list
        queue_ref(8'd3, 1'b0, $urandom_range(0, 8));
        queue_ref(8'd3, 1'b0, $urandom_range(0, 8));
        for (i = 0; i < 8; i++) queue_ref(8'd200 - 8'(i * 17), 1'b0, $urandom_range(0, 8));
        wait_all_results();

        // random phases, one frame limit each; odd phases run back to back
        for (i = 0; i < cap_plan.size(); i++) begin
            write_frame_limit(CFG_W'(cap_plan[i]));
            queue_random_refs(62, i[0]);
            wait_all_results();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("run covered %0d requests (%0d hits, %0d sequence ends) over %0d frame limits,",
                 n_requests, n_hits, n_ends, n_settings + 1);
        $display("including zero and clamped limits and a limit lowered under a full list");
        if (n_bad == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", n_bad);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
